// File: hw/rtl/lbpu_pkg.sv
// ---------------------------------------------------------------------------
// Lossless bitmap pixel unpacker: shared package
// Register indexes, reset values, pixel format codes and the structures that
// travel between the unpacker's modules.
// ---------------------------------------------------------------------------
package lbpu_pkg;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CFG_INDEX_W-1:0] REG_PIXEL_FORMAT  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_ALPHA_VARIANT = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH   = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT  = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_PALETTE_SIZE  = 3'd4;

  localparam logic [1:0] FMT_PALETTE = 2'd0;
  localparam logic [1:0] FMT_RGB     = 2'd1;

  localparam logic [1:0]  RST_PIXEL_FORMAT  = FMT_PALETTE;
  localparam logic        RST_ALPHA_VARIANT = 1'b0;
  localparam logic [15:0] RST_IMAGE_WIDTH   = 16'd1;
  localparam logic [15:0] RST_IMAGE_HEIGHT  = 16'd1;
  localparam logic [8:0]  RST_PALETTE_SIZE  = 9'd1;

  localparam logic [7:0] ALPHA_OPAQUE = 8'hff;

  localparam int TDATA_W = 64;

  typedef struct packed {
    logic [1:0]  pixel_format;
    logic        alpha_variant;
    logic [15:0] width;
    logic [15:0] height;
    logic [8:0]  load_count;
  } cfg_t;

  typedef struct packed {
    logic restart;
    logic load_palette;
  } restart_t;

  typedef struct packed {
    logic [15:0] x;
    logic [15:0] y;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic        bad_index;
    logic        last_pixel;
    logic        from_store;
  } pixel_t;

endpackage

// File: hw/rtl/lbpu_cfg.sv
// ---------------------------------------------------------------------------
// Lossless bitmap pixel unpacker: configuration registers
// Holds the five image registers and signals an image restart on each write to a known register.
// ---------------------------------------------------------------------------
module lbpu_cfg #(
  parameter int PALETTE_ENTRIES = 256
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [lbpu_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [lbpu_pkg::CFG_DATA_W-1:0]  cfg_data,
  output lbpu_pkg::cfg_t                   cfg,
  output lbpu_pkg::restart_t               restart
);

  localparam logic [8:0] ENTRY_LIMIT = 9'(PALETTE_ENTRIES);

  logic [1:0]  pixel_format, pixel_format_next;
  logic        alpha_variant, alpha_variant_next;
  logic [15:0] image_width, image_width_next;
  logic [15:0] image_height, image_height_next;
  logic [8:0]  palette_size, palette_size_next;
  logic        hit;
  logic [8:0]  load_count_next;

  assign cfg_ready = 1'b1;

  always_comb begin
    pixel_format_next  = pixel_format;
    alpha_variant_next = alpha_variant;
    image_width_next   = image_width;
    image_height_next  = image_height;
    palette_size_next  = palette_size;
    hit                = 1'b0;
    if (cfg_valid) begin
      case (cfg_index)
        lbpu_pkg::REG_PIXEL_FORMAT: begin
          pixel_format_next = cfg_data[1:0];
          hit = 1'b1;
        end
        lbpu_pkg::REG_ALPHA_VARIANT: begin
          alpha_variant_next = cfg_data[0];
          hit = 1'b1;
        end
        lbpu_pkg::REG_IMAGE_WIDTH: begin
          image_width_next = cfg_data[15:0];
          hit = 1'b1;
        end
        lbpu_pkg::REG_IMAGE_HEIGHT: begin
          image_height_next = cfg_data[15:0];
          hit = 1'b1;
        end
        lbpu_pkg::REG_PALETTE_SIZE: begin
          palette_size_next = cfg_data[8:0];
          hit = 1'b1;
        end
        default: begin
          hit = 1'b0;
        end
      endcase
    end
  end

  assign load_count_next = (palette_size_next > ENTRY_LIMIT) ? ENTRY_LIMIT : palette_size_next;

  assign restart.restart      = hit;
  assign restart.load_palette = (pixel_format_next == lbpu_pkg::FMT_PALETTE) &&
                                (load_count_next != 9'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_format  <= lbpu_pkg::RST_PIXEL_FORMAT;
      alpha_variant <= lbpu_pkg::RST_ALPHA_VARIANT;
      image_width   <= lbpu_pkg::RST_IMAGE_WIDTH;
      image_height  <= lbpu_pkg::RST_IMAGE_HEIGHT;
      palette_size  <= lbpu_pkg::RST_PALETTE_SIZE;
    end else begin
      pixel_format  <= pixel_format_next;
      alpha_variant <= alpha_variant_next;
      image_width   <= image_width_next;
      image_height  <= image_height_next;
      palette_size  <= palette_size_next;
    end
  end

  assign cfg.pixel_format  = pixel_format;
  assign cfg.alpha_variant = alpha_variant;
  assign cfg.width         = (image_width == 16'd0) ? 16'd1 : image_width;
  assign cfg.height        = (image_height == 16'd0) ? 16'd1 : image_height;
  assign cfg.load_count    = (palette_size > ENTRY_LIMIT) ? ENTRY_LIMIT : palette_size;

endmodule

// File: hw/rtl/lbpu_palette.sv
// ---------------------------------------------------------------------------
// Lossless bitmap pixel unpacker: palette store
// One write port and one registered read port, RGBA packed red in the top byte.
// ---------------------------------------------------------------------------
module lbpu_palette #(
  parameter int PALETTE_ENTRIES = 256
) (
  input  logic                               clk,
  input  logic                               wr_en,
  input  logic [$clog2(PALETTE_ENTRIES)-1:0] wr_addr,
  input  logic [31:0]                        wr_data,
  input  logic                               rd_en,
  input  logic [$clog2(PALETTE_ENTRIES)-1:0] rd_addr,
  output logic [31:0]                        rd_data
);

  logic [31:0] mem [PALETTE_ENTRIES];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: hw/rtl/lbpu_decode.sv
// ---------------------------------------------------------------------------
// Lossless bitmap pixel unpacker: byte decoder
// Tracks palette loading, byte phase, column, row and row padding, and
// registers each completed pixel.
// ---------------------------------------------------------------------------
module lbpu_decode #(
  parameter int PALETTE_ENTRIES = 256,
  parameter int ROW_ALIGN_BYTES = 4
) (
  input  logic                               clk,
  input  logic                               rst,
  input  lbpu_pkg::cfg_t                     cfg,
  input  lbpu_pkg::restart_t                 restart,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [7:0]                         s_tdata,
  input  logic                               s1_move,
  output logic                               s1_valid,
  output lbpu_pkg::pixel_t                   s1,
  output logic                               pal_wr_en,
  output logic [$clog2(PALETTE_ENTRIES)-1:0] pal_wr_addr,
  output logic [31:0]                        pal_wr_data,
  output logic                               pal_rd_en,
  output logic [$clog2(PALETTE_ENTRIES)-1:0] pal_rd_addr
);

  localparam int IDX_W = $clog2(PALETTE_ENTRIES);
  localparam int AL_W  = (ROW_ALIGN_BYTES > 1) ? $clog2(ROW_ALIGN_BYTES) : 1;
  localparam logic [AL_W-1:0] ALIGN_LAST = AL_W'(ROW_ALIGN_BYTES - 1);
  localparam logic LOADING_RST = (lbpu_pkg::RST_PIXEL_FORMAT == lbpu_pkg::FMT_PALETTE) &&
                                 (lbpu_pkg::RST_PALETTE_SIZE != 9'd0);

  logic             loading;
  logic [8:0]       fill;
  logic [1:0]       phase;
  logic [2:0][7:0]  held;
  logic [AL_W-1:0]  align;
  logic [15:0]      column;
  logic [15:0]      row;

  logic             accept;
  logic             palette_mode;
  logic [1:0]       last_phase;
  logic [1:0]       entry_last;
  logic             in_data;
  logic             completes;
  logic             emit;
  logic [16:0]      col_after;
  logic             row_end;
  logic             row_last;
  logic             entry_done;
  logic             good;
  logic [15:0]      c16;
  lbpu_pkg::pixel_t pix_next;

  assign palette_mode = (cfg.pixel_format == lbpu_pkg::FMT_PALETTE);
  assign last_phase   = palette_mode ? 2'd0 :
                        ((cfg.pixel_format == lbpu_pkg::FMT_RGB) && !cfg.alpha_variant) ?
                        2'd1 : 2'd3;
  assign entry_last   = cfg.alpha_variant ? 2'd3 : 2'd2;

  assign s_tready   = !s1_valid || s1_move;
  assign accept     = s_tvalid && s_tready;
  assign in_data    = column < cfg.width;
  assign completes  = (phase == last_phase);
  assign emit       = !loading && in_data && completes;
  assign col_after  = {1'b0, column} + 17'(emit);
  assign row_end    = !loading && (align == ALIGN_LAST) && (col_after == {1'b0, cfg.width});
  assign row_last   = ({1'b0, row} + 17'd1) == {1'b0, cfg.height};
  assign entry_done = loading && (phase == entry_last);
  assign good       = {1'b0, s_tdata} < cfg.load_count;
  assign c16        = {s_tdata, held[0]};

  assign pal_wr_en   = accept && entry_done;
  assign pal_wr_addr = fill[IDX_W-1:0];
  assign pal_wr_data = {held[0], held[1],
                        cfg.alpha_variant ? held[2] : s_tdata,
                        cfg.alpha_variant ? s_tdata : lbpu_pkg::ALPHA_OPAQUE};
  assign pal_rd_en   = accept;
  assign pal_rd_addr = s_tdata[IDX_W-1:0];

  always_comb begin
    pix_next.x          = column;
    pix_next.y          = row;
    pix_next.bad_index  = 1'b0;
    pix_next.from_store = 1'b0;
    pix_next.last_pixel = (({1'b0, column} + 17'd1) == {1'b0, cfg.width}) && row_last;
    pix_next.red        = held[1];
    pix_next.green      = held[2];
    pix_next.blue       = s_tdata;
    pix_next.alpha      = cfg.alpha_variant ? held[0] : lbpu_pkg::ALPHA_OPAQUE;
    if (palette_mode) begin
      pix_next.red        = 8'd0;
      pix_next.green      = 8'd0;
      pix_next.blue       = 8'd0;
      pix_next.alpha      = 8'd0;
      pix_next.bad_index  = !good;
      pix_next.from_store = good;
    end else if (last_phase == 2'd1) begin
      pix_next.red   = {c16[14:10], 3'b000};
      pix_next.green = {c16[9:5], 3'b000};
      pix_next.blue  = {c16[4:0], 3'b000};
      pix_next.alpha = lbpu_pkg::ALPHA_OPAQUE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      loading  <= LOADING_RST;
      fill     <= 9'd0;
      phase    <= 2'd0;
      held     <= '0;
      align    <= '0;
      column   <= 16'd0;
      row      <= 16'd0;
    end else begin
      if (accept) begin
        s1_valid <= emit;
      end else if (s1_move) begin
        s1_valid <= 1'b0;
      end
      if (restart.restart) begin
        loading <= restart.load_palette;
        fill    <= 9'd0;
        phase   <= 2'd0;
        held    <= '0;
        align   <= '0;
        column  <= 16'd0;
        row     <= 16'd0;
      end else if (accept) begin
        if (loading) begin
          if (!entry_done) begin
            held[phase] <= s_tdata;
            phase       <= phase + 2'd1;
          end else begin
            fill  <= fill + 9'd1;
            phase <= 2'd0;
            held  <= '0;
            if ((fill + 9'd1) >= cfg.load_count) begin
              loading <= 1'b0;
            end
          end
        end else begin
          if (row_end) begin
            align  <= '0;
            column <= 16'd0;
            phase  <= 2'd0;
            held   <= '0;
            if (row_last) begin
              row     <= 16'd0;
              fill    <= 9'd0;
              loading <= palette_mode && (cfg.load_count != 9'd0);
            end else begin
              row <= row + 16'd1;
            end
          end else begin
            align <= (align == ALIGN_LAST) ? '0 : align + AL_W'(1);
            if (in_data) begin
              if (!completes) begin
                held[phase] <= s_tdata;
                phase       <= phase + 2'd1;
              end else begin
                column <= col_after[15:0];
                phase  <= 2'd0;
                held   <= '0;
              end
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1 <= pix_next;
    end
  end

endmodule

// File: hw/rtl/lbpu_out.sv
// ---------------------------------------------------------------------------
// Lossless bitmap pixel unpacker: result register
// Merges the palette read with the decoded pixel and holds the output word.
// ---------------------------------------------------------------------------
module lbpu_out (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s1_valid,
  input  lbpu_pkg::pixel_t             s1,
  input  logic [31:0]                  pal_rd_data,
  output logic                         s1_move,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [lbpu_pkg::TDATA_W-1:0] m_tdata,
  output logic [0:0]                   m_tuser,
  output logic                         m_tlast
);

  logic [31:0] rgba;

  assign s1_move = !m_tvalid || m_tready;
  assign rgba    = s1.from_store ? pal_rd_data : {s1.red, s1.green, s1.blue, s1.alpha};

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s1_move) begin
      m_tvalid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move && s1_valid) begin
      m_tdata <= {rgba[7:0], rgba[15:8], rgba[23:16], rgba[31:24], s1.y, s1.x};
      m_tuser <= s1.bad_index;
      m_tlast <= s1.last_pixel;
    end
  end

endmodule

// File: hw/rtl/lossless_bitmap_pixel_unpacker.sv
// ---------------------------------------------------------------------------
// Lossless bitmap pixel unpacker
// Decodes an inflated lossless bitmap byte stream into pixels with coordinates.
// ---------------------------------------------------------------------------
// The input channel takes one byte of the inflated stream per word. In palette
// mode the palette entries come first and are loaded into the palette store;
// after that each byte is an index. In direct mode bytes are gathered into
// 15-bit or 32-bit pixels. Row padding bytes are consumed without output.
// The output channel carries one pixel per word, with tlast on the final
// pixel of the image and tuser set for a palette index beyond the palette.
// The configuration channel is always ready; every write to a known register
// restarts the image. It must be written only while the block is idle; the
// block does not enforce this. A byte that completes a pixel is caught in the
// decode register, with its palette read, at the edge that accepts it; the
// pixel then moves into the result register and onto the output once that
// register is free. One byte is accepted in every cycle while the receiver
// takes results; when the receiver stalls, the decode register still holds
// one more pixel before the input stops. Reset empties both registers, sets
// the registers to their defaults and starts a palette load.
// ---------------------------------------------------------------------------
module lossless_bitmap_pixel_unpacker #(
  parameter int PALETTE_ENTRIES = 256,
  parameter int ROW_ALIGN_BYTES = 4
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [7:0]                       s_tdata,   // data_byte
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [lbpu_pkg::TDATA_W-1:0]     m_tdata,   // pixel_x, pixel_y, red, green, blue, alpha
  output logic [0:0]                       m_tuser,   // bad_index
  output logic                             m_tlast,   // last_pixel
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [lbpu_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [lbpu_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int IDX_W = $clog2(PALETTE_ENTRIES);

  lbpu_pkg::cfg_t     cfg;
  lbpu_pkg::restart_t restart;
  lbpu_pkg::pixel_t   s1;
  logic               s1_valid;
  logic               s1_move;
  logic               pal_wr_en;
  logic [IDX_W-1:0]   pal_wr_addr;
  logic [31:0]        pal_wr_data;
  logic               pal_rd_en;
  logic [IDX_W-1:0]   pal_rd_addr;
  logic [31:0]        pal_rd_data;

  lbpu_cfg #(
    .PALETTE_ENTRIES(PALETTE_ENTRIES)
  ) u_cfg (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .cfg      (cfg),
    .restart  (restart)
  );

  lbpu_decode #(
    .PALETTE_ENTRIES(PALETTE_ENTRIES),
    .ROW_ALIGN_BYTES(ROW_ALIGN_BYTES)
  ) u_decode (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .restart    (restart),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s1_move    (s1_move),
    .s1_valid   (s1_valid),
    .s1         (s1),
    .pal_wr_en  (pal_wr_en),
    .pal_wr_addr(pal_wr_addr),
    .pal_wr_data(pal_wr_data),
    .pal_rd_en  (pal_rd_en),
    .pal_rd_addr(pal_rd_addr)
  );

  lbpu_palette #(
    .PALETTE_ENTRIES(PALETTE_ENTRIES)
  ) u_palette (
    .clk    (clk),
    .wr_en  (pal_wr_en),
    .wr_addr(pal_wr_addr),
    .wr_data(pal_wr_data),
    .rd_en  (pal_rd_en),
    .rd_addr(pal_rd_addr),
    .rd_data(pal_rd_data)
  );

  lbpu_out u_out (
    .clk        (clk),
    .rst        (rst),
    .s1_valid   (s1_valid),
    .s1         (s1),
    .pal_rd_data(pal_rd_data),
    .s1_move    (s1_move),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .m_tlast    (m_tlast)
  );

endmodule

// File: hw/rtl/lbpu_checker.sv
// ---------------------------------------------------------------------------
// Lossless bitmap pixel unpacker: port checker
// Concurrent assertions on the top level's ports, attached by a bind.
// ---------------------------------------------------------------------------
module lbpu_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         s_tready,
  input logic                         m_tvalid,
  input logic                         m_tready,
  input logic [lbpu_pkg::TDATA_W-1:0] m_tdata,
  input logic [0:0]                   m_tuser,
  input logic                         m_tlast,
  input logic                         cfg_valid,
  input logic                         cfg_ready
);

  // A stalled output word keeps its valid and its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser) &&
                              $stable(m_tlast))
    else $error("output word changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid after reset");

  // With the result register empty the input side must be open.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled while the output is empty");

  a_bad_index_black: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tdata[63:32] == 32'd0)
    else $error("bad index word carries colour");

  a_cfg_ready: assert property (@(posedge clk) disable iff (rst)
    cfg_valid |-> cfg_ready)
    else $error("configuration write refused");

endmodule

bind lossless_bitmap_pixel_unpacker lbpu_checker u_lbpu_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast),
  .cfg_valid(cfg_valid),
  .cfg_ready(cfg_ready)
);

// File: tb/tb.sv
// ---------------------------------------------------------------------------
// Testbench for the lossless bitmap pixel unpacker
// Writes the registers only while the block is idle and feeds palette and
// pixel bytes through the input stream. A short table of directed words comes
// first, then randomised images in palette, 1555, 32-bit and padded layouts.
// Every pixel word is checked field by field against a decoder kept in the
// testbench. Both sides idle and stall at varying rates, with one long
// receiver hold-off and one sender pause until every pixel has come out.
// ---------------------------------------------------------------------------
module tb;

  localparam int PAL_ENTRIES   = 256;
  localparam int ROW_ALIGN     = 4;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES   = 400;
  localparam int MAX_GAP       = 60;
  localparam int CYCLE_LIMIT   = 600000;
  localparam int PLAN_COUNT    = 13;

  localparam logic [1:0] FMT_ARGB  = 2'd2;
  localparam logic [1:0] FMT_SPARE = 2'd3;
  localparam logic [lbpu_pkg::CFG_INDEX_W-1:0] REG_UNUSED = 3'd7;

  typedef enum logic [1:0] {ROW_REG, ROW_BYTE, ROW_TYPED} row_kind_t;
  typedef enum logic [1:0] {PRESS_NONE, PRESS_HOLD, PRESS_PAUSE} press_t;

  typedef struct packed {
    logic [15:0] x;
    logic [15:0] y;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic        bad;
    logic        last;
  } pixel_rec_t;

  typedef struct packed {
    row_kind_t                        kind;
    logic [lbpu_pkg::CFG_INDEX_W-1:0] idx;
    logic [15:0]                      val;
    pixel_rec_t                       px;
  } script_row_t;

  typedef struct packed {
    logic [1:0]  fmt;
    logic        alpha;
    logic [15:0] w;
    logic [15:0] h;
    logic [8:0]  ps;
    logic [15:0] nbytes;
    logic [7:0]  src_pct;
    logic [7:0]  sink_pct;
    press_t      press;
  } image_plan_t;

  localparam pixel_rec_t NO_PIXEL = '0;

  logic                             clk;
  logic                             rst;
  logic                             s_tvalid;
  logic                             s_tready;
  logic [7:0]                       s_tdata;
  logic                             m_tvalid;
  logic                             m_tready;
  logic [lbpu_pkg::TDATA_W-1:0]     m_tdata;
  logic [0:0]                       m_tuser;
  logic                             m_tlast;
  logic                             cfg_valid;
  logic                             cfg_ready;
  logic [lbpu_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [lbpu_pkg::CFG_DATA_W-1:0]  cfg_data;

  lossless_bitmap_pixel_unpacker DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // Decoder state kept by the testbench.
  logic [1:0]  cur_format;
  logic        cur_alpha;
  logic [15:0] cur_width;
  logic [15:0] cur_height;
  logic [8:0]  cur_pal_size;
  logic [31:0] palette [PAL_ENTRIES];
  bit          pal_loading;
  int          pal_fill;
  int          byte_idx;
  logic [23:0] held;
  int          row_pos;
  int          col_pos;
  int          row_idx;

  pixel_rec_t  pending_pixels [$];
  script_row_t script [$];

  logic        typed_pending;
  pixel_rec_t  typed_px;
  int          src_idle_pct;
  int          sink_stall_pct;
  int          hold_requests;
  int          holds_done = 0;
  int          errors = 0;
  int          bytes_in = 0;
  int          pixels_out = 0;
  int          regs_written = 0;
  int          cycles = 0;

  function automatic int eff_w();
    return (cur_width == 16'd0) ? 1 : int'(cur_width);
  endfunction

  function automatic int eff_h();
    return (cur_height == 16'd0) ? 1 : int'(cur_height);
  endfunction

  function automatic int pal_count();
    return (int'(cur_pal_size) > PAL_ENTRIES) ? PAL_ENTRIES : int'(cur_pal_size);
  endfunction

  function automatic int pixel_bytes();
    if (cur_format == lbpu_pkg::FMT_PALETTE) return 1;
    if (cur_format == lbpu_pkg::FMT_RGB && !cur_alpha) return 2;
    return 4;
  endfunction

  task automatic restart_decode();
    pal_loading = (cur_format == lbpu_pkg::FMT_PALETTE) && (pal_count() > 0);
    pal_fill = 0;
    byte_idx = 0;
    held = '0;
    row_pos = 0;
    col_pos = 0;
    row_idx = 0;
  endtask

  task automatic reset_decoder();
    cur_format = lbpu_pkg::RST_PIXEL_FORMAT;
    cur_alpha = lbpu_pkg::RST_ALPHA_VARIANT;
    cur_width = lbpu_pkg::RST_IMAGE_WIDTH;
    cur_height = lbpu_pkg::RST_IMAGE_HEIGHT;
    cur_pal_size = lbpu_pkg::RST_PALETTE_SIZE;
    for (int i = 0; i < PAL_ENTRIES; i++) palette[i] = '0;
    restart_decode();
  endtask

  task automatic apply_reg(input logic [lbpu_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [lbpu_pkg::CFG_DATA_W-1:0] val);
    bit known;
    known = 1'b1;
    case (idx)
      lbpu_pkg::REG_PIXEL_FORMAT: cur_format = val[1:0];
      lbpu_pkg::REG_ALPHA_VARIANT: cur_alpha = val[0];
      lbpu_pkg::REG_IMAGE_WIDTH: cur_width = val[15:0];
      lbpu_pkg::REG_IMAGE_HEIGHT: cur_height = val[15:0];
      lbpu_pkg::REG_PALETTE_SIZE: cur_pal_size = val[8:0];
      default: known = 1'b0;
    endcase
    if (known) restart_decode();
  endtask

  task automatic unpack_byte(input logic [7:0] b, output bit made, output pixel_rec_t px);
    int          data_bytes;
    int          pitch;
    int          entry_bytes;
    int          bpp;
    logic [7:0]  r;
    logic [7:0]  g;
    logic [7:0]  bl;
    logic [7:0]  a;
    logic        bad;
    logic [15:0] c;
    logic [31:0] e;
    made = 1'b0;
    px = NO_PIXEL;
    bpp = pixel_bytes();
    data_bytes = eff_w() * bpp;
    pitch = data_bytes + (ROW_ALIGN - data_bytes % ROW_ALIGN) % ROW_ALIGN;
    if (pal_loading) begin
      entry_bytes = cur_alpha ? 4 : 3;
      if (byte_idx + 1 < entry_bytes) begin
        held = held | (24'(b) << (8 * byte_idx));
        byte_idx++;
      end else begin
        r = held[7:0];
        g = held[15:8];
        if (entry_bytes == 4) begin
          bl = held[23:16];
          a = b;
        end else begin
          bl = b;
          a = lbpu_pkg::ALPHA_OPAQUE;
        end
        if (pal_fill < PAL_ENTRIES) palette[pal_fill & 255] = {r, g, bl, a};
        pal_fill++;
        byte_idx = 0;
        held = '0;
        if (pal_fill >= pal_count()) pal_loading = 1'b0;
      end
    end else begin
      if (row_pos < data_bytes) begin
        if (byte_idx + 1 < bpp) begin
          held = held | (24'(b) << (8 * byte_idx));
          byte_idx++;
        end else begin
          r = '0;
          g = '0;
          bl = '0;
          a = lbpu_pkg::ALPHA_OPAQUE;
          bad = 1'b0;
          if (bpp == 1) begin
            if (int'(b) < pal_count()) begin
              e = palette[b];
              r = e[31:24];
              g = e[23:16];
              bl = e[15:8];
              a = e[7:0];
            end else begin
              a = '0;
              bad = 1'b1;
            end
          end else if (bpp == 2) begin
            c = {b, held[7:0]};
            r = {c[14:10], 3'b000};
            g = {c[9:5], 3'b000};
            bl = {c[4:0], 3'b000};
          end else begin
            a = cur_alpha ? held[7:0] : lbpu_pkg::ALPHA_OPAQUE;
            r = held[15:8];
            g = held[23:16];
            bl = b;
          end
          px.x = col_pos[15:0];
          px.y = row_idx[15:0];
          px.red = r;
          px.green = g;
          px.blue = bl;
          px.alpha = a;
          px.bad = bad;
          px.last = (col_pos + 1 == eff_w()) && (row_idx + 1 == eff_h());
          made = 1'b1;
          col_pos++;
          byte_idx = 0;
          held = '0;
        end
      end
      row_pos++;
      if (row_pos >= pitch) begin
        row_pos = 0;
        col_pos = 0;
        byte_idx = 0;
        held = '0;
        row_idx++;
        if (row_idx >= eff_h()) restart_decode();
      end
    end
  endtask

  task automatic flag_mismatch(input string what, input pixel_rec_t want, input pixel_rec_t saw);
    errors++;
    if (errors <= 10) begin
      $display("%s: expected x=%0d y=%0d rgba=%02h%02h%02h%02h bad=%0b last=%0b",
               what, want.x, want.y, want.red, want.green, want.blue, want.alpha, want.bad,
               want.last);
      $display("%s: got      x=%0d y=%0d rgba=%02h%02h%02h%02h bad=%0b last=%0b",
               what, saw.x, saw.y, saw.red, saw.green, saw.blue, saw.alpha, saw.bad,
               saw.last);
    end
  endtask

  always @(posedge clk) begin
    pixel_rec_t next_px;
    pixel_rec_t seen;
    bit         made;
    if (rst) begin
      reset_decoder();
    end else begin
      if (cfg_valid && cfg_ready) begin
        apply_reg(cfg_index, cfg_data);
        regs_written++;
      end
      if (s_tvalid && s_tready) begin
        unpack_byte(s_tdata, made, next_px);
        bytes_in++;
        if (typed_pending) pending_pixels = {pending_pixels, typed_px};
        else if (made) pending_pixels = {pending_pixels, next_px};
      end
      if (m_tvalid && m_tready) begin
        seen.x = m_tdata[15:0];
        seen.y = m_tdata[31:16];
        seen.red = m_tdata[39:32];
        seen.green = m_tdata[47:40];
        seen.blue = m_tdata[55:48];
        seen.alpha = m_tdata[63:56];
        seen.bad = m_tuser[0];
        seen.last = m_tlast;
        pixels_out++;
        if (pending_pixels.size() == 0) begin
          flag_mismatch("unexpected pixel", NO_PIXEL, seen);
        end else begin
          next_px = pending_pixels.pop_front();
          if (seen !== next_px) flag_mismatch("pixel mismatch", next_px, seen);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Receiver: random stalls, or a long counted hold-off when one is requested.
  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_requests != holds_done) begin
        holds_done++;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else begin
        m_tready <= (int'($urandom_range(99)) >= sink_stall_pct);
      end
    end
  end

  function automatic int pick_gap();
    int g;
    g = 0;
    while (g < MAX_GAP && int'($urandom_range(99)) < src_idle_pct) g++;
    return g;
  endfunction

  // Palette indices mostly fall inside the loaded palette; padding and
  // direct pixel bytes are fully random.
  function automatic logic [7:0] pick_byte();
    if (pal_loading || cur_format != lbpu_pkg::FMT_PALETTE || pal_count() == 0 ||
        row_pos >= eff_w() * pixel_bytes())
      return 8'($urandom_range(255));
    if ($urandom_range(99) < 85) return 8'($urandom_range(pal_count() - 1));
    return 8'($urandom_range(255));
  endfunction

  task automatic send_byte(input logic [7:0] value, input bit typed, input pixel_rec_t want,
                           input bit fresh);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    if (fresh) value = pick_byte();
    s_tvalid <= 1'b1;
    s_tdata <= value;
    typed_pending <= typed;
    typed_px <= want;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic write_reg(input logic [lbpu_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [lbpu_pkg::CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_idle();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_pixels.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  function automatic pixel_rec_t pix(input logic [15:0] x, input logic [15:0] y,
                                     input logic [7:0] r, input logic [7:0] g,
                                     input logic [7:0] b, input logic [7:0] a,
                                     input logic bad, input logic last);
    pix = '{x: x, y: y, red: r, green: g, blue: b, alpha: a, bad: bad, last: last};
  endfunction

  function automatic script_row_t step_row(input row_kind_t kind,
                                           input logic [lbpu_pkg::CFG_INDEX_W-1:0] idx,
                                           input logic [15:0] val, input pixel_rec_t px);
    step_row = '{kind: kind, idx: idx, val: val, px: px};
  endfunction

  task automatic add_row(input script_row_t r);
    script = {script, r};
  endtask

  task automatic build_script();
    // After reset: palette mode, one RGB entry, a one by one image.
    add_row(step_row(ROW_BYTE, REG_UNUSED, 16'h0012, NO_PIXEL));
    add_row(step_row(ROW_BYTE, REG_UNUSED, 16'h0034, NO_PIXEL));
    add_row(step_row(ROW_BYTE, REG_UNUSED, 16'h0056, NO_PIXEL));
    // A write to an unknown register must not restart the image.
    add_row(step_row(ROW_REG, REG_UNUSED, 16'hffff, NO_PIXEL));
    add_row(step_row(ROW_TYPED, REG_UNUSED, 16'h0000,
                     pix(16'd0, 16'd0, 8'h12, 8'h34, 8'h56, 8'hff, 1'b0, 1'b1)));
    add_row(step_row(ROW_BYTE, REG_UNUSED, 16'h00ff, NO_PIXEL));
    add_row(step_row(ROW_BYTE, REG_UNUSED, 16'h0000, NO_PIXEL));
    add_row(step_row(ROW_BYTE, REG_UNUSED, 16'h00aa, NO_PIXEL));
    // Empty palette and zero width: every index is bad.
    add_row(step_row(ROW_REG, lbpu_pkg::REG_PALETTE_SIZE, 16'h0000, NO_PIXEL));
    add_row(step_row(ROW_REG, lbpu_pkg::REG_IMAGE_WIDTH, 16'h0000, NO_PIXEL));
    add_row(step_row(ROW_TYPED, REG_UNUSED, 16'h00ff,
                     pix(16'd0, 16'd0, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 1'b1)));
    // 1555 pixels, two to a row.
    add_row(step_row(ROW_REG, lbpu_pkg::REG_PIXEL_FORMAT, 16'(lbpu_pkg::FMT_RGB), NO_PIXEL));
    add_row(step_row(ROW_REG, lbpu_pkg::REG_IMAGE_WIDTH, 16'd2, NO_PIXEL));
    add_row(step_row(ROW_BYTE, REG_UNUSED, 16'h00ff, NO_PIXEL));
    add_row(step_row(ROW_TYPED, REG_UNUSED, 16'h00ff,
                     pix(16'd0, 16'd0, 8'hf8, 8'hf8, 8'hf8, 8'hff, 1'b0, 1'b0)));
    add_row(step_row(ROW_BYTE, REG_UNUSED, 16'h0000, NO_PIXEL));
    add_row(step_row(ROW_TYPED, REG_UNUSED, 16'h0000,
                     pix(16'd1, 16'd0, 8'h00, 8'h00, 8'h00, 8'hff, 1'b0, 1'b1)));
    add_row(step_row(ROW_BYTE, REG_UNUSED, 16'h001f, NO_PIXEL));
    add_row(step_row(ROW_BYTE, REG_UNUSED, 16'h007c, NO_PIXEL));
    // 32-bit pixels with alpha taken from the first byte.
    add_row(step_row(ROW_REG, lbpu_pkg::REG_ALPHA_VARIANT, 16'd1, NO_PIXEL));
    add_row(step_row(ROW_REG, lbpu_pkg::REG_IMAGE_WIDTH, 16'd1, NO_PIXEL));
    add_row(step_row(ROW_BYTE, REG_UNUSED, 16'h0000, NO_PIXEL));
    add_row(step_row(ROW_BYTE, REG_UNUSED, 16'h00ff, NO_PIXEL));
    add_row(step_row(ROW_BYTE, REG_UNUSED, 16'h0000, NO_PIXEL));
    add_row(step_row(ROW_TYPED, REG_UNUSED, 16'h00ff,
                     pix(16'd0, 16'd0, 8'hff, 8'h00, 8'hff, 8'h00, 1'b0, 1'b1)));
    // The spare format code decodes as 32-bit, here without alpha.
    add_row(step_row(ROW_REG, lbpu_pkg::REG_PIXEL_FORMAT, 16'(FMT_SPARE), NO_PIXEL));
    add_row(step_row(ROW_REG, lbpu_pkg::REG_ALPHA_VARIANT, 16'd0, NO_PIXEL));
    add_row(step_row(ROW_BYTE, REG_UNUSED, 16'h0011, NO_PIXEL));
    add_row(step_row(ROW_BYTE, REG_UNUSED, 16'h0022, NO_PIXEL));
    add_row(step_row(ROW_BYTE, REG_UNUSED, 16'h0033, NO_PIXEL));
    add_row(step_row(ROW_BYTE, REG_UNUSED, 16'h0044, NO_PIXEL));
  endtask

  function automatic image_plan_t plan_of(input int i);
    case (i)
      0: plan_of = '{lbpu_pkg::FMT_PALETTE, 1'b0, 16'd3, 16'd2, 9'd4, 16'd60, 8'd0, 8'd0,
                     PRESS_NONE};
      1: plan_of = '{lbpu_pkg::FMT_PALETTE, 1'b1, 16'd5, 16'd3, 9'd16, 16'd90, 8'd88, 8'd0,
                     PRESS_NONE};
      2: plan_of = '{lbpu_pkg::FMT_PALETTE, 1'b0, 16'd2, 16'd2, 9'd511, 16'd300, 8'd0, 8'd88,
                     PRESS_NONE};
      3: plan_of = '{lbpu_pkg::FMT_RGB, 1'b0, 16'd1, 16'd1, 9'd1, 16'd40, 8'd38, 8'd38,
                     PRESS_NONE};
      4: plan_of = '{lbpu_pkg::FMT_RGB, 1'b0, 16'd3, 16'd4, 9'd1, 16'd60, 8'd0, 8'd0,
                     PRESS_PAUSE};
      5: plan_of = '{FMT_ARGB, 1'b0, 16'd7, 16'd2, 9'd1, 16'd70, 8'd88, 8'd0, PRESS_NONE};
      6: plan_of = '{FMT_ARGB, 1'b1, 16'd1, 16'd65535, 9'd1, 16'd60, 8'd0, 8'd88,
                     PRESS_NONE};
      7: plan_of = '{lbpu_pkg::FMT_RGB, 1'b1, 16'd4, 16'd3, 9'd1, 16'd60, 8'd38, 8'd38,
                     PRESS_NONE};
      8: plan_of = '{FMT_SPARE, 1'b1, 16'd2, 16'd1, 9'd1, 16'd40, 8'd0, 8'd0, PRESS_NONE};
      9: plan_of = '{lbpu_pkg::FMT_PALETTE, 1'b0, 16'd65535, 16'd65535, 9'd2, 16'd100,
                     8'd0, 8'd0, PRESS_HOLD};
      10: plan_of = '{lbpu_pkg::FMT_RGB, 1'b0, 16'd65535, 16'd65535, 9'd1, 16'd60, 8'd38,
                      8'd38, PRESS_NONE};
      11: plan_of = '{lbpu_pkg::FMT_PALETTE, 1'b1, 16'd1, 16'd1, 9'd1, 16'd40, 8'd88, 8'd0,
                      PRESS_NONE};
      default: plan_of = '{lbpu_pkg::FMT_PALETTE, 1'b0, 16'd6, 16'd2, 9'd0, 16'd40, 8'd0,
                           8'd88, PRESS_NONE};
    endcase
  endfunction

  initial begin
    image_plan_t plan;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    typed_pending = 1'b0;
    typed_px = NO_PIXEL;
    src_idle_pct = 0;
    sink_stall_pct = 0;
    hold_requests = 0;
    build_script();
    repeat (7) @(negedge clk);
    rst <= 1'b0;

    foreach (script[i]) begin
      case (script[i].kind)
        ROW_REG: begin
          wait_idle();
          write_reg(script[i].idx, script[i].val);
        end
        ROW_TYPED: send_byte(script[i].val[7:0], 1'b1, script[i].px, 1'b0);
        default: send_byte(script[i].val[7:0], 1'b0, NO_PIXEL, 1'b0);
      endcase
    end

    for (int p = 0; p < PLAN_COUNT; p++) begin
      plan = plan_of(p);
      wait_idle();
      src_idle_pct = int'(plan.src_pct);
      sink_stall_pct = int'(plan.sink_pct);
      write_reg(lbpu_pkg::REG_PIXEL_FORMAT, 16'(plan.fmt));
      write_reg(lbpu_pkg::REG_ALPHA_VARIANT, 16'(plan.alpha));
      write_reg(lbpu_pkg::REG_IMAGE_WIDTH, plan.w);
      write_reg(lbpu_pkg::REG_IMAGE_HEIGHT, plan.h);
      write_reg(lbpu_pkg::REG_PALETTE_SIZE, 16'(plan.ps));
      if (plan.press == PRESS_HOLD) hold_requests++;
      for (int k = 0; k < int'(plan.nbytes); k++) begin
        if (plan.press == PRESS_PAUSE && k == int'(plan.nbytes) / 2) wait_idle();
        send_byte(8'h00, 1'b0, NO_PIXEL, 1'b1);
      end
    end

    wait_idle();
    $display("Fed %0d bytes and checked %0d pixels across %0d register writes,",
             bytes_in, pixels_out, regs_written);
    $display("covering palette, 1555 and 32-bit layouts with %0d mismatches.", errors);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
